>>> rtl/core/bpis_pkg.sv
// types, constants and codes shared by the bsp point-in-solid query block
`timescale 1ns / 1ps

package bpis_pkg;

  localparam int NODE_COUNT_DEF  = 1024;
  localparam int PLANE_COUNT_DEF = 1024;
  localparam int DEPTH_LIMIT_DEF = 64;

  localparam int CODE_W = 11;
  localparam logic [CODE_W-1:0] CODE_EMPTY = 11'd1024;
  localparam logic [CODE_W-1:0] CODE_SOLID = 11'd1025;

  localparam int SUM_W = 50;

  typedef enum logic [1:0] {
    OP_WR_NODE  = 2'd0,
    OP_WR_PLANE = 2'd1,
    OP_QUERY    = 2'd2
  } op_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NODE,
    ST_PLANE,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         slot;
    logic [9:0]         plane_ref;
    logic [10:0]        front_child;
    logic [10:0]        back_child;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [31:0] plane_offset;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
  } in_item_t;

  typedef struct packed {
    logic       in_solid;
    logic       depth_fault;
    logic [6:0] steps_taken;
  } out_item_t;

  typedef struct packed {
    logic [10:0] back_child;
    logic [10:0] front_child;
    logic [9:0]  plane_ref;
  } node_t;

  typedef struct packed {
    logic signed [15:0] norm_z;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_x;
    logic signed [31:0] offset;
  } plane_t;

  typedef struct packed {
    logic wr_node;
    logic wr_plane;
    logic start;
    logic node_rd;
    logic plane_rd;
    logic mul;
    logic sum;
    logic advance;
    logic set_fault;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic leaf;
    logic at_limit;
  } dp_status_t;

endpackage

>>> rtl/core/bpis_datapath.sv
// node and plane stores, plane distance arithmetic and result register
`timescale 1ns / 1ps

module bpis_datapath
  import bpis_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  ctl_cmd_t   cmd,
  output dp_status_t sts,
  output out_item_t  out_data
);

  localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int PIW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int SW  = $clog2(DEPTH_LIMIT + 1);

  node_t  node_mem  [NODE_COUNT];
  plane_t plane_mem [PLANE_COUNT];

  node_t              node_q_r;
  logic               node_oob_r;
  node_t              cur_r;
  plane_t             plane_q_r;
  logic               plane_oob_r;
  logic [CODE_W-1:0]  code_r;
  logic [SW-1:0]      step_r;
  logic               fault_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [47:0] prod_x_r, prod_y_r, prod_z_r;
  logic signed [45:0] term_o_r;
  logic signed [SUM_W-1:0] sum_r;
  out_item_t          out_r;

  node_t              node_eff;
  logic               node_wr_ok;
  logic               plane_wr_ok;

  assign node_eff    = node_oob_r ? '0 : node_q_r;
  assign node_wr_ok  = 32'(in_data.slot) < NODE_COUNT;
  assign plane_wr_ok = 32'(in_data.slot) < PLANE_COUNT;

  // node store
  always_ff @(posedge clk) begin
    if (cmd.wr_node && node_wr_ok) begin
      node_mem[NIW'(in_data.slot)] <= '{back_child:  in_data.back_child,
                                        front_child: in_data.front_child,
                                        plane_ref:   in_data.plane_ref};
    end
    if (cmd.node_rd) begin
      node_q_r <= node_mem[NIW'(code_r)];
    end
  end

  // plane store
  always_ff @(posedge clk) begin
    if (cmd.wr_plane && plane_wr_ok) begin
      plane_mem[PIW'(in_data.slot)] <= '{norm_z: in_data.norm_z,
                                         norm_y: in_data.norm_y,
                                         norm_x: in_data.norm_x,
                                         offset: in_data.plane_offset};
    end
    if (cmd.plane_rd) begin
      plane_q_r <= plane_mem[PIW'(node_eff.plane_ref)];
    end
  end

  // walk control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r  <= '0;
      step_r  <= '0;
      fault_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        code_r  <= '0;
        step_r  <= '0;
        fault_r <= 1'b0;
      end
      if (cmd.plane_rd) begin
        step_r <= step_r + SW'(1);
      end
      if (cmd.advance) begin
        code_r <= sum_r[SUM_W-1] ? cur_r.back_child : cur_r.front_child;
      end
      if (cmd.set_fault) begin
        fault_r <= 1'b1;
      end
    end
  end

  // arithmetic and payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= in_data.pt_x;
      py_r <= in_data.pt_y;
      pz_r <= in_data.pt_z;
    end
    if (cmd.node_rd) begin
      node_oob_r <= !(32'(code_r) < NODE_COUNT);
    end
    if (cmd.plane_rd) begin
      cur_r       <= node_eff;
      plane_oob_r <= !(32'(node_eff.plane_ref) < PLANE_COUNT);
    end
    if (cmd.mul) begin
      if (plane_oob_r) begin
        prod_x_r <= '0;
        prod_y_r <= '0;
        prod_z_r <= '0;
        term_o_r <= '0;
      end else begin
        prod_x_r <= 48'(plane_q_r.norm_x) * 48'(px_r);
        prod_y_r <= 48'(plane_q_r.norm_y) * 48'(py_r);
        prod_z_r <= 48'(plane_q_r.norm_z) * 48'(pz_r);
        term_o_r <= {plane_q_r.offset, 14'b0};
      end
    end
    if (cmd.sum) begin
      sum_r <= SUM_W'(prod_x_r) + SUM_W'(prod_y_r) + SUM_W'(prod_z_r) + SUM_W'(term_o_r);
    end
    if (cmd.load_out) begin
      out_r.in_solid    <= !fault_r && (code_r == CODE_SOLID);
      out_r.depth_fault <= fault_r;
      out_r.steps_taken <= 7'(step_r);
    end
  end

  assign sts.leaf     = code_r >= CODE_EMPTY;
  assign sts.at_limit = 32'(step_r) >= DEPTH_LIMIT;
  assign out_data     = out_r;

endmodule

>>> rtl/core/bpis_ctrl.sv
// walk sequencer and channel handshakes
`timescale 1ns / 1ps

module bpis_ctrl
  import bpis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output ctl_cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (op_e_t'(in_opcode))
            OP_WR_NODE:  cmd.wr_node  = 1'b1;
            OP_WR_PLANE: cmd.wr_plane = 1'b1;
            OP_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = ST_CHECK;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (sts.leaf) begin
          state_nxt = ST_DONE;
        end else if (sts.at_limit) begin
          cmd.set_fault = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = ST_NODE;
        end
      end
      ST_NODE: begin
        cmd.plane_rd = 1'b1;
        state_nxt    = ST_PLANE;
      end
      ST_PLANE: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/bsp_point_in_solid_query.sv
// top level of the bsp point-in-solid query block
//
// in_ channel: one item per handshake; opcode selects a node write, a plane
// write or a point query. writes land in the store in the accepting cycle and
// give no result. a query walks the tree from root node 0 and gives one
// out_ item: in_solid, depth_fault and steps_taken.
// a walk visits at most DEPTH_LIMIT interior nodes, one at a time; each
// node costs a node store read, a plane store read, a multiply stage, a
// sum stage and a child select. one query is in flight at a time: no new
// item is taken until its walk ends and its result is loaded. writes are
// taken back to back.
// in_ready is high only in the idle state, after a walk has loaded its
// result; a finished result waits in the output register, so new items are
// taken while out_ready is low. a walk that ends while the previous result
// is still held waits for it. reset clears the sequencer and the result
// valid; the stores hold garbage until written and need no clearing pass.
`timescale 1ns / 1ps

module bsp_point_in_solid_query
  import bpis_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ctl_cmd_t   cmd;
  dp_status_t sts;

  bpis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpis_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT),
    .DEPTH_LIMIT (DEPTH_LIMIT)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/bpis_checker.sv
// port-level assertions for the bsp point-in-solid query block
`timescale 1ns / 1ps

module bpis_checker
  import bpis_pkg::*;
#(
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_fault_not_solid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.in_solid && out_data.depth_fault))
    else $error("faulted walk reported solid");

  a_fault_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.depth_fault |-> out_data.steps_taken == 7'(DEPTH_LIMIT))
    else $error("faulted walk step count is not the depth bound");

endmodule

bind bsp_point_in_solid_query bpis_checker #(
  .DEPTH_LIMIT (DEPTH_LIMIT)
) u_bpis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
